@@ rtl/sitda_pkg.sv @@
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies.
package sitda_pkg;

  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_WIDTH  = 4 * BCD_DIGITS;
  localparam int unsigned DCNT_WIDTH = 5;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef logic [BCD_WIDTH-1:0] bcd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

endpackage

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// Signed integer to decimal ASCII text converter, top level.
// Depends on sitda_pkg and sitda_bcd_step.
// Sequence: one shift-and-add-3 step per value bit through the single BCD step unit, then
// up to 19 leading zero digits are skipped, then the minus sign of a negative value and one
// character per digit are sent; sending the sign and the digits waits on output back-pressure.
// A new value is accepted only once the last character of the previous one has been issued.
// Reset clears the sequencer and the output valid; no item is in flight afterwards.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] text_char
  output logic        m_axis_tlast    // last_char
);

  localparam int unsigned CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

  sitda_pkg::state_e state_q, state_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic neg_q, neg_d;
  logic [CNT_WIDTH-1:0] bit_cnt_q, bit_cnt_d;
  sitda_pkg::bcd_t bcd_q, bcd_d;
  logic [sitda_pkg::DCNT_WIDTH-1:0] dcnt_q, dcnt_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic out_last_q, out_last_d;

  logic [VALUE_WIDTH-1:0] raw;
  logic raw_neg;
  sitda_pkg::bcd_t bcd_step;
  logic [3:0] top_digit;
  logic out_free;

  assign raw       = s_axis_tdata[VALUE_WIDTH-1:0];
  assign raw_neg   = raw[VALUE_WIDTH-1];
  assign top_digit = bcd_q[sitda_pkg::BCD_WIDTH-1 -: 4];
  assign out_free  = !out_valid_q || m_axis_tready;

  sitda_bcd_step u_step (
    .bcd_i (bcd_q),
    .bit_i (mag_q[VALUE_WIDTH-1]),
    .bcd_o (bcd_step)
  );

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    bit_cnt_d   = bit_cnt_q;
    bcd_d       = bcd_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (state_q)
      sitda_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          neg_d     = raw_neg;
          mag_d     = raw_neg ? (~raw + 1'b1) : raw;
          bit_cnt_d = CNT_WIDTH'(VALUE_WIDTH);
          bcd_d     = '0;
          dcnt_d    = sitda_pkg::DCNT_WIDTH'(sitda_pkg::BCD_DIGITS);
          state_d   = sitda_pkg::ST_CONVERT;
        end
      end
      sitda_pkg::ST_CONVERT: begin
        bcd_d     = bcd_step;
        mag_d     = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == CNT_WIDTH'(1)) begin
          state_d = sitda_pkg::ST_SKIP;
        end
      end
      sitda_pkg::ST_SKIP: begin
        if (top_digit == 4'd0 && dcnt_q != sitda_pkg::DCNT_WIDTH'(1)) begin
          bcd_d  = {bcd_q[sitda_pkg::BCD_WIDTH-5:0], 4'd0};
          dcnt_d = dcnt_q - 1'b1;
        end else begin
          state_d = neg_q ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
        end
      end
      sitda_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sitda_pkg::CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = sitda_pkg::ST_EMIT;
        end
      end
      sitda_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sitda_pkg::CHAR_ZERO + {4'd0, top_digit};
          out_last_d  = (dcnt_q == sitda_pkg::DCNT_WIDTH'(1));
          bcd_d       = {bcd_q[sitda_pkg::BCD_WIDTH-5:0], 4'd0};
          dcnt_d      = dcnt_q - 1'b1;
          if (dcnt_q == sitda_pkg::DCNT_WIDTH'(1)) begin
            state_d = sitda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sitda_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sitda_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    bit_cnt_q  <= bit_cnt_d;
    bcd_q      <= bcd_d;
    dcnt_q     <= dcnt_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = (state_q == sitda_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/sitda_bcd_step.sv @@
// One shift-and-add-3 step of the binary to BCD conversion.
// Depends on sitda_pkg.
module sitda_bcd_step (
  input  sitda_pkg::bcd_t bcd_i,
  input  logic            bit_i,
  output sitda_pkg::bcd_t bcd_o
);

  sitda_pkg::bcd_t adj;

  always_comb begin
    for (int i = 0; i < sitda_pkg::BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_i[4*i +: 4] >= 4'd5) ? bcd_i[4*i +: 4] + 4'd3
                                                 : bcd_i[4*i +: 4];
    end
  end

  assign bcd_o = {adj[sitda_pkg::BCD_WIDTH-2:0], bit_i};

endmodule
